@@ rtl/pcf_pkg.sv @@
package pcf_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  // position of the last header byte; CRC bytes follow it
  localparam logic [3:0] PosBody  = 4'd7;
  localparam logic [3:0] PosFinal = 4'd11;

  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       chunk_done;
    logic       error;
  } out_t;

  // one queued job for the serializer
  typedef struct packed {
    logic        hdr;       // length + type bytes lead the run
    logic        with_crc;  // four CRC bytes close the run
    logic        err;
    logic [30:0] len;
    logic [31:0] ctype;     // data entries carry their byte in [7:0]
    logic [31:0] crc;       // already inverted
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = CrcPoly ^ (r >> 1);
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/png_chunk_framer_crc32.sv @@
// A data word taken is written into the queue, then loaded into the output register.
// A start word hashes its type bytes into the header CRC, one a cycle if the queue has room.
// One data word is taken per cycle while the queue has room; a start word stalls the input.
// Each queued job sends 1, 5, 8 or 12 bytes via the output register, one per cycle unless stalled.
// Reset (rst_ni low, asynchronous) empties the two-entry queue and closes any open chunk.
module png_chunk_framer_crc32 import pcf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head;

  pcf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  pcf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  pcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/pcf_front.sv @@
module pcf_front import pcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_t     in_data_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output job_t    push_job_o
);

  typedef enum logic [1:0] {
    FS_IDLE = 2'b01,
    FS_HASH = 2'b10
  } fstate_e;

  fstate_e     st_q, st_d;
  logic [31:0] crc_q, crc_d;
  logic [30:0] remain_q, remain_d;
  logic        open_q, open_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] type_q, type_d;
  logic [30:0] len_q, len_d;
  logic        err_q, err_d;

  logic        accept;
  logic [7:0]  hash_b;
  logic [31:0] crc_n;

  assign in_stall_o = (st_q != FS_IDLE) || q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (cnt_q)
      2'd1:    hash_b = type_q[23:16];
      2'd2:    hash_b = type_q[15:8];
      default: hash_b = type_q[7:0];
    endcase
  end

  always_comb begin
    st_d       = st_q;
    crc_d      = crc_q;
    remain_d   = remain_q;
    open_d     = open_q;
    cnt_d      = cnt_q;
    type_d     = type_q;
    len_d      = len_q;
    err_d      = err_q;
    push_o     = 1'b0;
    push_job_o = '0;
    crc_n      = crc_byte(crc_q, (st_q == FS_HASH) ? hash_b : in_data_i.data_byte);
    unique case (st_q)
      FS_IDLE: begin
        if (accept && in_data_i.op == OpStart) begin
          err_d  = open_q;
          type_d = in_data_i.chunk_type;
          len_d  = in_data_i.chunk_length;
          crc_d  = crc_byte(CrcOnes, in_data_i.chunk_type[31:24]);
          cnt_d  = 2'd1;
          st_d   = FS_HASH;
          if (in_data_i.chunk_length != '0) begin
            open_d   = 1'b1;
            remain_d = in_data_i.chunk_length;
          end else begin
            open_d   = 1'b0;
            remain_d = '0;
          end
        end else if (accept) begin
          push_o = 1'b1;
          if (open_q) begin
            crc_d                = crc_n;
            remain_d             = remain_q - 31'd1;
            push_job_o.with_crc  = (remain_q == 31'd1);
            push_job_o.ctype     = {24'd0, in_data_i.data_byte};
            push_job_o.crc       = ~crc_n;
            if (remain_q == 31'd1) begin
              open_d = 1'b0;
            end
          end else begin
            // no chunk open: the byte is dropped and an error job is queued
            push_job_o.err = 1'b1;
          end
        end
      end
      FS_HASH: begin
        if (!q_stat_i.full) begin
          crc_d = crc_n;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            push_o              = 1'b1;
            push_job_o.hdr      = 1'b1;
            push_job_o.with_crc = (len_q == '0);
            push_job_o.err      = err_q;
            push_job_o.len      = len_q;
            push_job_o.ctype    = type_q;
            push_job_o.crc      = ~crc_n;
            st_d                = FS_IDLE;
          end
        end
      end
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= FS_IDLE;
      crc_q    <= CrcOnes;
      remain_q <= '0;
      open_q   <= 1'b0;
      cnt_q    <= '0;
      err_q    <= 1'b0;
    end else begin
      st_q     <= st_d;
      crc_q    <= crc_d;
      remain_q <= remain_d;
      open_q   <= open_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    len_q  <= len_d;
  end

endmodule

@@ rtl/pcf_fifo.sv @@
module pcf_fifo import pcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ rtl/pcf_back.sv @@
module pcf_back import pcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    head_i,
  input  q_stat_t q_stat_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output out_t    out_data_o
);

  logic [3:0] pos_q, pos_d;
  logic [3:0] pos;
  logic [3:0] pos_end;
  logic       load;
  logic       out_valid_q;
  out_t       out_q, out_d;
  logic [7:0] sel_byte;
  logic [31:0] len_w;

  assign len_w   = {1'b0, head_i.len};
  // data runs start at the body slot
  assign pos     = (!head_i.hdr && pos_q < PosBody) ? PosBody : pos_q;
  assign pos_end = head_i.with_crc ? PosFinal : PosBody;
  assign load    = (!out_valid_q || !out_stall_i) && !q_stat_i.empty;
  assign pop_o   = load && (pos == pos_end);

  always_comb begin
    case (pos)
      4'd0:    sel_byte = len_w[31:24];
      4'd1:    sel_byte = len_w[23:16];
      4'd2:    sel_byte = len_w[15:8];
      4'd3:    sel_byte = len_w[7:0];
      4'd4:    sel_byte = head_i.ctype[31:24];
      4'd5:    sel_byte = head_i.ctype[23:16];
      4'd6:    sel_byte = head_i.ctype[15:8];
      4'd7:    sel_byte = head_i.ctype[7:0];
      4'd8:    sel_byte = head_i.crc[31:24];
      4'd9:    sel_byte = head_i.crc[23:16];
      4'd10:   sel_byte = head_i.crc[15:8];
      default: sel_byte = head_i.crc[7:0];
    endcase
  end

  always_comb begin
    out_d.out_byte    = sel_byte;
    out_d.last_of_run = (pos == pos_end);
    out_d.chunk_done  = head_i.with_crc && (pos == PosFinal);
    out_d.error       = head_i.err;
    pos_d             = pos_q;
    if (load) begin
      pos_d = (pos == pos_end) ? 4'd0 : pos + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= !q_stat_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
